@@ sv/oahi_pkg.sv @@
// Package for the open-address hash insert core.
// Holds table sizing, configuration register indexes, status codes and the FSM type.
// No dependencies.
package oahi_pkg;

    localparam int SLOTS     = 128;
    localparam int IDX_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int SIZE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int STATUS_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(SLOTS);
    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd47;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_HOLD
    } t_state;

endpackage

@@ sv/oahi_cfg_if.sv @@
// Configuration write channel of the hash insert core.
// Depends on oahi_pkg.
interface oahi_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [oahi_pkg::CFG_IDX_W-1:0]     index;
    logic [oahi_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/oahi_in_if.sv @@
// Input channel of the hash insert core: one signed character per transaction.
// Depends on oahi_pkg.
interface oahi_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [oahi_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

@@ sv/oahi_out_if.sv @@
// Result channel of the hash insert core: status, probe count and slot index.
// Depends on oahi_pkg.
interface oahi_out_if;
    logic                               valid;
    logic                               ready;
    logic [oahi_pkg::STATUS_W-1:0]      status;
    logic [oahi_pkg::IDX_W-1:0]         probe_count;
    logic [oahi_pkg::IDX_W-1:0]         slot_index;

    modport source (output valid, output status, output probe_count, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input probe_count, input slot_index,
                    output ready);
endinterface

@@ sv/open_address_hash_insert_core.sv @@
// Open-address hash insert core: top level with slot memory and probe sequencer.
// Depends on oahi_pkg, oahi_cfg_if, oahi_in_if, oahi_out_if.
//
// Each input transaction inserts one signed character into a table of up to 128 one-byte
// slots held in a single synchronous RAM. One item is processed at a time: the core accepts
// it, reduces the character modulo the table size (two remainder bits per cycle), then
// probes slot by slot, the RAM's single read port being streamed one probe address per
// cycle. The next transaction is accepted only after the item's final probe step;
// if the output register is still occupied, the block waits until the result is taken.
// A configuration write clears the whole table by clearing the per-slot valid flags;
// no clearing pass is needed after reset.
module open_address_hash_insert_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    oahi_cfg_if.sink     i_cfg,
    oahi_in_if.sink      i_in,
    oahi_out_if.source   o_out
);
    import oahi_pkg::*;

    t_state                 r_state, n_state;
    logic [SIZE_W-1:0]      r_size;
    logic                   r_mode;
    logic [CHAR_W-1:0]      r_code;
    logic                   r_neg;
    logic [CHAR_W-1:0]      r_dvd;
    logic [SIZE_W-1:0]      r_rem;
    logic [1:0]             r_cnt;
    logic [IDX_W-1:0]       r_q;
    logic [IDX_W-1:0]       r_d;
    logic [IDX_W-1:0]       r_m;
    logic [SLOTS-1:0]       r_vld;
    logic [CHAR_W-1:0]      r_mem [SLOTS];
    logic [CHAR_W-1:0]      r_rd_data;
    logic                   r_rd_vld;
    logic [STATUS_W-1:0]    r_res_status;
    logic [IDX_W-1:0]       r_res_count;
    logic [IDX_W-1:0]       r_res_idx;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [IDX_W-1:0]       r_out_count;
    logic [IDX_W-1:0]       r_out_idx;

    logic                   cfg_we;
    logic [SIZE_W-1:0]      cfg_size;
    logic                   in_ready;
    logic                   in_take;
    logic [CHAR_W-1:0]      mag;
    logic [SIZE_W-1:0]      rem1, rem2, home8;
    logic [IDX_W-1:0]       home;
    logic [CHAR_W-1:0]      held;
    logic [SIZE_W-1:0]      q_sum, d_sum;
    logic [IDX_W-1:0]       q_next, d_next;
    logic                   last;
    logic                   out_free;
    logic [IDX_W-1:0]       rd_addr;
    logic                   mem_we;
    logic                   res_done;
    logic [STATUS_W-1:0]    res_status;
    logic [IDX_W-1:0]       res_count;
    logic [IDX_W-1:0]       res_idx;
    logic                   out_load;

    function automatic logic [SIZE_W-1:0] mod_step(logic [SIZE_W-1:0] rem, logic din,
                                                   logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] t;
        t = {rem[SIZE_W-2:0], din};
        if (t >= size) begin
            t = t - size;
        end
        return t;
    endfunction

    // configuration
    assign i_cfg.ready = 1'b1;
    assign cfg_we = i_cfg.valid && i_cfg.ready &&
                    (i_cfg.index == CFG_TABLE_SIZE || i_cfg.index == CFG_PROBE_MODE);
    assign cfg_size = (i_cfg.data == '0) ? SIZE_W'(1) :
                      (i_cfg.data > SIZE_MAX) ? SIZE_MAX : i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_mode <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_TABLE_SIZE: r_size <= cfg_size;
                CFG_PROBE_MODE: r_mode <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // datapath
    assign in_ready = (r_state == ST_IDLE);
    assign i_in.ready = in_ready;
    assign in_take = i_in.valid && in_ready;
    assign mag = i_in.char_code[CHAR_W-1] ? (~i_in.char_code + CHAR_W'(1)) : i_in.char_code;

    assign rem1  = mod_step(r_rem, r_dvd[CHAR_W-1], r_size);
    assign rem2  = mod_step(rem1, r_dvd[CHAR_W-2], r_size);
    assign home8 = (r_neg && rem2 != '0) ? (r_size - rem2) : rem2;
    assign home  = home8[IDX_W-1:0];

    assign held   = r_rd_vld ? r_rd_data : '0;
    assign q_sum  = {1'b0, r_q} + {1'b0, r_d};
    assign q_next = (q_sum >= r_size) ? IDX_W'(q_sum - r_size) : q_sum[IDX_W-1:0];
    assign d_sum  = {1'b0, r_d} + SIZE_W'(2);
    assign d_next = !r_mode ? IDX_W'(1) :
                    (d_sum >= r_size) ? IDX_W'(d_sum - r_size) : d_sum[IDX_W-1:0];
    assign last   = (({1'b0, r_m} + SIZE_W'(1)) == r_size);
    assign out_free = !r_out_valid || o_out.ready;

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        rd_addr    = q_next;
        mem_we     = 1'b0;
        res_done   = 1'b0;
        res_status = STATUS_FULL;
        res_count  = '0;
        res_idx    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                rd_addr = home;
                if (r_cnt == 2'd3) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (held == '0) begin
                    mem_we     = 1'b1;
                    res_done   = 1'b1;
                    res_status = STATUS_INSERTED;
                    res_count  = r_m;
                    res_idx    = r_q;
                end else if (held == r_code) begin
                    res_done   = 1'b1;
                    res_status = STATUS_PRESENT;
                end else if (last) begin
                    res_done   = 1'b1;
                end
                if (res_done) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code <= i_in.char_code;
            r_neg  <= i_in.char_code[CHAR_W-1];
            r_dvd  <= mag;
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (r_state == ST_MOD) begin
            r_rem <= rem2;
            r_dvd <= {r_dvd[CHAR_W-3:0], 2'b00};
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_q <= home;
                r_m <= '0;
                r_d <= IDX_W'(1);
            end
        end
        if (r_state == ST_PROBE && !res_done) begin
            r_q <= q_next;
            r_m <= r_m + IDX_W'(1);
            r_d <= d_next;
        end
        if (res_done) begin
            r_res_status <= res_status;
            r_res_count  <= res_count;
            r_res_idx    <= res_idx;
        end
    end

    // slot memory; valid flags give the cleared view
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_q] <= r_code;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_vld <= '0;
            end else if (mem_we) begin
                r_vld[r_q] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    // output register
    assign out_load = ((r_state == ST_PROBE && res_done) || r_state == ST_HOLD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == ST_HOLD) begin
                r_out_status <= r_res_status;
                r_out_count  <= r_res_count;
                r_out_idx    <= r_res_idx;
            end else begin
                r_out_status <= res_status;
                r_out_count  <= res_count;
                r_out_idx    <= res_idx;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.probe_count = r_out_count;
    assign o_out.slot_index  = r_out_idx;

endmodule
